// ----- src/hsv_to_rgb_converter_assert.svh -----
// Assertion macros for the HSV to RGB converter.
// HSV_ASSERT_IMP: same-cycle implication. HSV_ASSERT_NXT: next-cycle implication.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv_to_rgb_converter: assertion failed");
`define HSV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv_to_rgb_converter: assertion failed");
`else
`define HSV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HSV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    typedef struct packed {
        logic signed [15:0] hue;
        logic [7:0]         saturation;
        logic [7:0]         brightness;
    } t_hsv_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       range_error;
    } t_rgb_pixel;

    // hue units per 60 degree sector, and the span of sectors -1..6
    localparam int SECTOR_UNITS = 960;
    localparam int HUE_SPAN     = 8 * SECTOR_UNITS;

    // how the back end builds the pixel
    localparam logic [1:0] KIND_HUE   = 2'd0;
    localparam logic [1:0] KIND_BLACK = 2'd1;
    localparam logic [1:0] KIND_GREY  = 2'd2;
    localparam logic [1:0] KIND_RANGE = 2'd3;

    // hue sectors after folding 6 onto 0 and -1 onto 5
    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;
    localparam logic [2:0] SEC_MR = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] sector;
        logic [9:0] rem;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_hsv2rgb_job;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] sector;
        logic [7:0] brightness;
    } t_hsv2rgb_tag;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

// ----- src/hsv_to_rgb_converter.sv -----
// HSV to RGB pixel converter. Takes one pixel per clock and delivers one RGB pixel per
// input, in order, sustaining one pixel per clock while the output side keeps up. Each
// pixel is registered by the hue classification register at the input transfer edge,
// then passes through the four-entry queue and the arithmetic pipeline (fraction,
// saturation terms, value scaling, divide by 255, channel select) to the output. When
// the output stalls, the pipeline and queue fill and then the input stall rises; the
// front end stalls only when the queue is full. Hue is in 1/16 degree, sectors -1
// through 6 are valid, black and grey pixels bypass the hue check.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  hsv2rgb_pkg::t_hsv_pixel i_pixel,
    output logic                    o_valid,
    input  logic                    i_stall,
    output hsv2rgb_pkg::t_rgb_pixel o_pixel
);
    import hsv2rgb_pkg::*;

    logic         w_f_valid;
    logic         w_q_full;
    t_hsv2rgb_job w_f_job;
    logic         w_q_valid;
    logic         w_back_stall;
    t_hsv2rgb_job w_q_job;
    logic         w_q_pop;

    hsv2rgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (w_f_valid),
        .i_stall (w_q_full),
        .o_job   (w_f_job)
    );

    hsv2rgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_stall (w_q_full),
        .i_job   (w_f_job),
        .o_valid (w_q_valid),
        .i_stall (w_back_stall),
        .o_job   (w_q_job)
    );

    hsv2rgb_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_stall (w_back_stall),
        .i_job   (w_q_job),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

    assign w_q_pop = w_q_valid && !w_back_stall;

    `HSV_ASSERT_IMP(a_err_black, i_clk, i_rst_n, o_valid && o_pixel.range_error,
        (o_pixel.red == 8'd0) && (o_pixel.green == 8'd0) && (o_pixel.blue == 8'd0))
    `HSV_ASSERT_NXT(a_full_holds, i_clk, i_rst_n, w_q_full && !w_q_pop, w_q_full)
    `HSV_ASSERT_NXT(a_front_holds, i_clk, i_rst_n, o_stall, w_f_valid)

endmodule

// ----- src/hsv2rgb_front.sv -----
module hsv2rgb_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  hsv2rgb_pkg::t_hsv_pixel   i_pixel,
    output logic                      o_valid,
    input  logic                      i_stall,
    output hsv2rgb_pkg::t_hsv2rgb_job o_job
);
    import hsv2rgb_pkg::*;

    logic signed [16:0] w_shift;
    logic               w_out;
    logic [12:0]        w_pos;
    logic [12:0]        w_base;
    logic [2:0]         w_idx;
    logic               w_take;
    t_hsv2rgb_job       n_job;
    t_hsv2rgb_job       r_job;
    logic               r_vld;

    always_comb begin
        // shift by one sector so sector -1 lands on index 0
        w_shift = 17'(i_pixel.hue) + 17'(SECTOR_UNITS);
        w_out   = w_shift[16] || (w_shift >= 17'(HUE_SPAN));
        w_pos   = w_shift[12:0];
        w_idx   = '0;
        w_base  = '0;
        for (int k = 1; k < 8; k++) begin
            if (w_pos >= 13'(k * SECTOR_UNITS)) begin
                w_idx  = 3'(k);
                w_base = 13'(k * SECTOR_UNITS);
            end
        end

        n_job.saturation = i_pixel.saturation;
        n_job.brightness = i_pixel.brightness;
        n_job.rem        = 10'(w_pos - w_base);
        case (w_idx)
            3'd0:    n_job.sector = SEC_MR;
            3'd7:    n_job.sector = SEC_RY;
            default: n_job.sector = 3'(w_idx - 3'd1);
        endcase

        if (i_pixel.brightness == 8'd0) begin
            n_job.kind = KIND_BLACK;
        end else if (i_pixel.saturation == 8'd0) begin
            n_job.kind = KIND_GREY;
        end else if (w_out) begin
            n_job.kind = KIND_RANGE;
        end else begin
            n_job.kind = KIND_HUE;
        end
    end

    assign o_stall = r_vld && i_stall;
    assign w_take  = i_valid && !o_stall;
    assign o_valid = r_vld;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= n_job;
        end
    end

endmodule

// ----- src/hsv2rgb_queue.sv -----
module hsv2rgb_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  hsv2rgb_pkg::t_hsv2rgb_job i_job,
    output logic                      o_valid,
    input  logic                      i_stall,
    output hsv2rgb_pkg::t_hsv2rgb_job o_job
);
    import hsv2rgb_pkg::*;

    t_hsv2rgb_job          r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_cnt;
    logic                  w_push;
    logic                  w_pop;

    assign o_stall = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- src/hsv2rgb_back.sv -----
module hsv2rgb_back #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  hsv2rgb_pkg::t_hsv2rgb_job i_job,
    output logic                      o_valid,
    input  logic                      i_stall,
    output hsv2rgb_pkg::t_rgb_pixel   o_pixel
);
    import hsv2rgb_pkg::*;

    localparam int FB = FRACTION_BITS;
    // floor(y/15) = (y * RECIP15) >> (FB+8), exact for y below 2^(FB+4)
    localparam logic [FB+4:0] RECIP15 =
        (FB + 5)'(((64'd1 << (FB + 8)) + 64'd14) / 64'd15);
    localparam int RECIP15_SHIFT = FB + 8;
    // floor(z/255) = (z * 65794) >> 24, exact for 16-bit z
    localparam logic [16:0] RECIP255 = 17'd65794;
    localparam int RECIP255_SHIFT = 24;
    localparam logic [FB:0]   ONE  = (FB + 1)'(1) << FB;
    localparam logic [FB+7:0] FULL = (FB + 8)'(255) << FB;

    logic w_adv0, w_adv1, w_adv2, w_adv3, w_adv4;
    logic r_vld0, r_vld1, r_vld2, r_vld3, r_vld4;

    // stage 0: fraction
    logic [FB+3:0]   w_y;
    logic [2*FB+8:0] w_fprod;
    logic [FB-1:0]   r_f0;
    logic [7:0]      r_s0;
    t_hsv2rgb_tag    r_tag0;

    // stage 1: saturation terms
    logic [FB+7:0]   w_sf;
    logic [FB+7:0]   w_sg;
    logic [FB:0]     w_gf;
    logic [FB+7:0]   r_aq1;
    logic [FB+7:0]   r_at1;
    logic [7:0]      r_sinv1;
    t_hsv2rgb_tag    r_tag1;

    // stage 2: scale by value
    logic [FB+15:0]  w_pq;
    logic [FB+15:0]  w_pt;
    logic [15:0]     w_pp;
    logic [15:0]     r_zq2;
    logic [15:0]     r_zt2;
    logic [15:0]     r_zp2;
    t_hsv2rgb_tag    r_tag2;

    // stage 3: divide by 255
    logic [32:0]     w_dq;
    logic [32:0]     w_dt;
    logic [32:0]     w_dp;
    logic [7:0]      r_q3;
    logic [7:0]      r_t3;
    logic [7:0]      r_p3;
    t_hsv2rgb_tag    r_tag3;

    // stage 4: channel select
    t_rgb_pixel      n_pix;
    t_rgb_pixel      r_pix4;

    assign w_adv4  = !r_vld4 || !i_stall;
    assign w_adv3  = !r_vld3 || w_adv4;
    assign w_adv2  = !r_vld2 || w_adv3;
    assign w_adv1  = !r_vld1 || w_adv2;
    assign w_adv0  = !r_vld0 || w_adv1;
    assign o_stall = !w_adv0;
    assign o_valid = r_vld4;
    assign o_pixel = r_pix4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (w_adv0) begin
                r_vld0 <= i_valid;
            end
            if (w_adv1) begin
                r_vld1 <= r_vld0;
            end
            if (w_adv2) begin
                r_vld2 <= r_vld1;
            end
            if (w_adv3) begin
                r_vld3 <= r_vld2;
            end
            if (w_adv4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    // rem * 2^FB / 960 == (rem << (FB-6)) / 15
    assign w_y     = (FB + 4)'(i_job.rem) << (FB - 6);
    assign w_fprod = w_y * RECIP15;

    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_f0              <= w_fprod[RECIP15_SHIFT +: FB];
            r_s0              <= i_job.saturation;
            r_tag0.kind       <= i_job.kind;
            r_tag0.sector     <= i_job.sector;
            r_tag0.brightness <= i_job.brightness;
        end
    end

    assign w_gf = ONE - {1'b0, r_f0};
    assign w_sf = r_s0 * r_f0;
    assign w_sg = r_s0 * w_gf;

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_aq1   <= FULL - w_sf;
            r_at1   <= FULL - w_sg;
            r_sinv1 <= 8'd255 - r_s0;
            r_tag1  <= r_tag0;
        end
    end

    assign w_pq = r_tag1.brightness * r_aq1;
    assign w_pt = r_tag1.brightness * r_at1;
    assign w_pp = r_tag1.brightness * r_sinv1;

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_zq2  <= w_pq[FB +: 16];
            r_zt2  <= w_pt[FB +: 16];
            r_zp2  <= w_pp;
            r_tag2 <= r_tag1;
        end
    end

    assign w_dq = r_zq2 * RECIP255;
    assign w_dt = r_zt2 * RECIP255;
    assign w_dp = r_zp2 * RECIP255;

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_q3   <= w_dq[RECIP255_SHIFT +: 8];
            r_t3   <= w_dt[RECIP255_SHIFT +: 8];
            r_p3   <= w_dp[RECIP255_SHIFT +: 8];
            r_tag3 <= r_tag2;
        end
    end

    always_comb begin
        n_pix = '0;
        case (r_tag3.kind)
            KIND_GREY: begin
                n_pix.red   = r_tag3.brightness;
                n_pix.green = r_tag3.brightness;
                n_pix.blue  = r_tag3.brightness;
            end
            KIND_RANGE: begin
                n_pix.range_error = 1'b1;
            end
            KIND_HUE: begin
                case (r_tag3.sector)
                    SEC_RY: begin
                        n_pix.red = r_tag3.brightness; n_pix.green = r_t3; n_pix.blue = r_p3;
                    end
                    SEC_YG: begin
                        n_pix.red = r_q3; n_pix.green = r_tag3.brightness; n_pix.blue = r_p3;
                    end
                    SEC_GC: begin
                        n_pix.red = r_p3; n_pix.green = r_tag3.brightness; n_pix.blue = r_t3;
                    end
                    SEC_CB: begin
                        n_pix.red = r_p3; n_pix.green = r_q3; n_pix.blue = r_tag3.brightness;
                    end
                    SEC_BM: begin
                        n_pix.red = r_t3; n_pix.green = r_p3; n_pix.blue = r_tag3.brightness;
                    end
                    SEC_MR: begin
                        n_pix.red = r_tag3.brightness; n_pix.green = r_p3; n_pix.blue = r_q3;
                    end
                    default: begin
                        n_pix = '0;
                    end
                endcase
            end
            default: begin
                n_pix = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_pix4 <= n_pix;
        end
    end

endmodule

// ----- bench/hsv_to_rgb_converter_checker.sv -----
module hsv_to_rgb_converter_checker #(
    parameter int FRACTION_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_hsv_valid,
    input  logic                    i_hsv_stall,
    input  hsv2rgb_pkg::t_hsv_pixel i_hsv_pixel,
    input  logic                    i_rgb_valid,
    input  logic                    i_rgb_stall,
    input  hsv2rgb_pkg::t_rgb_pixel i_rgb_pixel,
    output int                      o_mismatches,
    output int                      o_pending,
    output int                      o_compared
);
    timeunit 1ns;
    timeprecision 1ps;
    import hsv2rgb_pkg::*;

    // bias in whole sectors that makes every 16-bit hue non-negative before dividing
    localparam int HUE_BIAS     = 35;
    localparam int FIRST_SECTOR = -1;
    localparam int LAST_SECTOR  = 6;

    t_rgb_pixel expected_rgb[$];

    function automatic t_rgb_pixel convert_hsv(t_hsv_pixel px);
        t_rgb_pixel rgb;
        longint     val, sat, biased, rem, frac, frac_one, full, p, q, t;
        int         sector;
        logic [2:0] folded;
        rgb = '0;
        val = px.brightness;
        sat = px.saturation;
        if (val == 0) begin
            return rgb;
        end
        if (sat == 0) begin
            rgb.red   = px.brightness;
            rgb.green = px.brightness;
            rgb.blue  = px.brightness;
            return rgb;
        end
        biased = longint'($signed(px.hue)) + HUE_BIAS * SECTOR_UNITS;
        sector = int'(biased / SECTOR_UNITS) - HUE_BIAS;
        rem    = biased % SECTOR_UNITS;
        if (sector < FIRST_SECTOR || sector > LAST_SECTOR) begin
            rgb.range_error = 1'b1;
            return rgb;
        end
        frac_one = longint'(1) << FRACTION_BITS;
        frac     = (rem << FRACTION_BITS) / SECTOR_UNITS;
        full     = 255 * frac_one;
        p = val * (255 - sat) / 255;
        q = val * (full - sat * frac) / full;
        t = val * (full - sat * (frac_one - frac)) / full;
        // wrap-around sectors reuse their neighbors' channel mapping
        if (sector == LAST_SECTOR) begin
            folded = SEC_RY;
        end else if (sector == FIRST_SECTOR) begin
            folded = SEC_MR;
        end else begin
            folded = sector[2:0];
        end
        case (folded)
            SEC_RY: begin
                rgb.red = 8'(val); rgb.green = 8'(t); rgb.blue = 8'(p);
            end
            SEC_YG: begin
                rgb.red = 8'(q); rgb.green = 8'(val); rgb.blue = 8'(p);
            end
            SEC_GC: begin
                rgb.red = 8'(p); rgb.green = 8'(val); rgb.blue = 8'(t);
            end
            SEC_CB: begin
                rgb.red = 8'(p); rgb.green = 8'(q); rgb.blue = 8'(val);
            end
            SEC_BM: begin
                rgb.red = 8'(t); rgb.green = 8'(p); rgb.blue = 8'(val);
            end
            default: begin
                rgb.red = 8'(val); rgb.green = 8'(p); rgb.blue = 8'(q);
            end
        endcase
        return rgb;
    endfunction

    task automatic check_field(string label, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (!i_rst_n) begin
            o_mismatches = 0;
            o_compared   = 0;
            o_pending   <= 0;
        end else begin
            if (i_hsv_valid && !i_hsv_stall) begin
                expected_rgb.push_back(convert_hsv(i_hsv_pixel));
            end
            if (i_rgb_valid && !i_rgb_stall) begin
                if (expected_rgb.size() == 0) begin
                    $display("%0t: result with nothing expected, actual r=%0d g=%0d b=%0d err=%0d",
                             $time, i_rgb_pixel.red, i_rgb_pixel.green, i_rgb_pixel.blue,
                             i_rgb_pixel.range_error);
                    o_mismatches++;
                end else begin
                    want = expected_rgb.pop_front();
                    check_field("red", want.red, i_rgb_pixel.red);
                    check_field("green", want.green, i_rgb_pixel.green);
                    check_field("blue", want.blue, i_rgb_pixel.blue);
                    check_field("range_error", want.range_error, i_rgb_pixel.range_error);
                    o_compared++;
                end
            end
            o_pending <= expected_rgb.size();
        end
    end

endmodule

// ----- bench/hsv_to_rgb_converter_test.sv -----
module hsv_to_rgb_converter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hsv2rgb_pkg::*;

    localparam int FRACTION_BITS = 10;
    localparam int RANDOM_PIXELS = 750;
    localparam int CALM_TAIL     = 100;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LOW_HUE       = -SECTOR_UNITS;
    localparam int HIGH_HUE      = HUE_SPAN - SECTOR_UNITS - 1;

    logic       clk;
    logic       rst_n;
    logic       hsv_valid;
    logic       hsv_stall;
    t_hsv_pixel hsv_pixel;
    logic       rgb_valid;
    logic       rgb_stall;
    t_rgb_pixel rgb_pixel;

    int mismatches;
    int pending;
    int compared;
    int cycles;
    int sent;
    int black_cnt;
    int grey_cnt;
    int bad_hue_cnt;
    int wrap_cnt;
    int in_gap_pct;
    int out_stall_pct;
    bit calm;

    hsv_to_rgb_converter #(
        .FRACTION_BITS(FRACTION_BITS)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (hsv_valid),
        .o_stall (hsv_stall),
        .i_pixel (hsv_pixel),
        .o_valid (rgb_valid),
        .i_stall (rgb_stall),
        .o_pixel (rgb_pixel)
    );

    hsv_to_rgb_converter_checker #(
        .FRACTION_BITS(FRACTION_BITS)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_hsv_valid  (hsv_valid),
        .i_hsv_stall  (hsv_stall),
        .i_hsv_pixel  (hsv_pixel),
        .i_rgb_valid  (rgb_valid),
        .i_rgb_stall  (rgb_stall),
        .i_rgb_pixel  (rgb_pixel),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    function automatic t_hsv_pixel hsv(int hue, int sat, int val);
        t_hsv_pixel px;
        px.hue        = 16'(hue);
        px.saturation = 8'(sat);
        px.brightness = 8'(val);
        return px;
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // zero and full scale show up often so grey, black and saturated pixels are common
    function automatic int edge_byte();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 255;
            default: return int'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(t_hsv_pixel px);
        int hue_val;
        hue_val = $signed(px.hue);
        if (!calm && $urandom_range(99) < in_gap_pct) begin
            hsv_valid <= 1'b0;
            hsv_pixel <= t_hsv_pixel'($urandom());
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        hsv_valid <= 1'b1;
        hsv_pixel <= px;
        sent++;
        if (px.brightness == 0) begin
            black_cnt++;
        end else if (px.saturation == 0) begin
            grey_cnt++;
        end else if (hue_val < LOW_HUE || hue_val > HIGH_HUE) begin
            bad_hue_cnt++;
        end else if (hue_val < 0 || hue_val >= 6 * SECTOR_UNITS) begin
            wrap_cnt++;
        end
        // transfer completes at the first edge where the block is not stalling
        do @(posedge clk); while (hsv_stall);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
        $display("hsv_to_rgb_converter verification failed");
        $finish;
    end

    initial begin
        int span;
        rgb_stall <= 1'b0;
        out_stall_pct = 0;
        span = 0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (!calm && $urandom_range(99) < out_stall_pct) begin
                rgb_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                rgb_stall <= 1'b0;
            end
            @(posedge clk);
            span++;
            if (span % 150 == 0) begin
                out_stall_pct = pick_rate();
            end
        end
    end

    initial begin
        int hue_val;
        rst_n     <= 1'b0;
        hsv_valid <= 1'b0;
        hsv_pixel <= '0;
        calm       = 1'b0;
        in_gap_pct = 0;
        sent        = 0;
        black_cnt   = 0;
        grey_cnt    = 0;
        bad_hue_cnt = 0;
        wrap_cnt    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_pixel(hsv(0, 255, 255));
        send_pixel(hsv(959, 255, 255));
        send_pixel(hsv(960, 200, 180));
        send_pixel(hsv(2400, 128, 255));
        send_pixel(hsv(3360, 255, 100));
        send_pixel(hsv(4320, 77, 255));
        send_pixel(hsv(5280, 255, 1));
        send_pixel(hsv(5760, 255, 255));     // first hue of sector six
        send_pixel(hsv(6719, 180, 200));     // last hue of sector six
        send_pixel(hsv(6720, 255, 255));     // one past the valid range
        send_pixel(hsv(-1, 255, 255));       // top of sector minus one
        send_pixel(hsv(-960, 100, 150));     // bottom of sector minus one
        send_pixel(hsv(-961, 255, 255));
        send_pixel(hsv(-32768, 255, 255));
        send_pixel(hsv(32767, 1, 1));
        send_pixel(hsv(-32768, 0, 0));       // black wins over a bad hue
        send_pixel(hsv(32767, 0, 255));      // grey wins over a bad hue
        send_pixel(hsv(12345, 0, 77));
        send_pixel(hsv(-20000, 200, 0));
        send_pixel(hsv(1500, 1, 255));
        send_pixel(hsv(4000, 255, 128));
        send_pixel(hsv(480, 254, 254));

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % 64 == 0) begin
                in_gap_pct = pick_rate();
            end
            if (n == RANDOM_PIXELS - CALM_TAIL) begin
                calm = 1'b1;
            end
            if ($urandom_range(9) < 7) begin
                hue_val = LOW_HUE + int'($urandom_range(HUE_SPAN - 1));
            end else begin
                hue_val = int'($urandom());
            end
            send_pixel(hsv(hue_val, edge_byte(), edge_byte()));
        end
        hsv_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d pixels sent: %0d black, %0d grey, %0d with hue out of range, %0d in the",
                 sent, black_cnt, grey_cnt, bad_hue_cnt, wrap_cnt);
        $display("wrap sectors; %0d results compared under random input gaps and output stalls",
                 compared);
        if (mismatches == 0 && pending == 0) begin
            $display("hsv_to_rgb_converter verification clean");
        end else begin
            $display("hsv_to_rgb_converter verification failed");
        end
        $finish;
    end

endmodule
